[hw/rtl/cqb_pkg.sv]
// Package for the consolidated quote book: sizes, payload structs, entry mapping.
`default_nettype none
package cqb_pkg;

    localparam int NUM_SOURCES = 16;
    localparam int NUM_ENTRIES = 2 * NUM_SOURCES;
    localparam int EW          = $clog2(NUM_ENTRIES);
    localparam int SW          = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int TW          = 36;
    localparam int CW          = 5;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;
    localparam logic SIDE_ASK   = 1'b0;
    localparam logic SIDE_BID   = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic               side;
        logic [3:0]         source_index;
        logic signed [31:0] price;
        logic [31:0]        size;
    } t_item;

    typedef struct packed {
        logic               ask_present;
        logic signed [31:0] best_ask_price;
        logic [TW-1:0]      best_ask_total;
        logic               bid_present;
        logic signed [31:0] best_bid_price;
        logic [TW-1:0]      best_bid_total;
        logic [CW-1:0]      crossed_removed;
    } t_result;

    typedef struct packed {
        logic signed [31:0] price;
        logic [31:0]        size;
    } t_quote;

    // entry = side * NUM_SOURCES + source
    function automatic logic [EW-1:0] entry_of(input logic sd, input logic [3:0] src);
        logic [EW-1:0] base;
        logic [EW-1:0] ofs;
        base = (sd == SIDE_BID) ? EW'(NUM_SOURCES) : '0;
        ofs  = EW'(src);
        return base + ofs;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/consolidated_quote_book_top.sv]
// Consolidated quote book: per-source ask/bid quotes, crossing removal, best-level readout.
`default_nettype none
// One transaction is taken when start is high and busy is low; its result appears on
// o_result for exactly one cycle with o_strobe high, and the receiver cannot stall it.
// Each transaction runs from accept to the next possible accept in these steps: the
// addressed quote is read at accept and updated in the check state, then a sweep of
// the quote memory one source per cycle, reading the ask and the bid entry of that
// source through its two read ports, which removes crossed quotes and builds the best
// levels, then the drain state to finish the last entry; the strobe follows as the
// block returns to idle. Held flags sit in flip-flops, so reset needs no clearing pass.
module consolidated_quote_book_top
    import cqb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_item   i_item,
    output logic         o_strobe,
    output t_result      o_result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    localparam logic [6:0] NS7 = 7'(NUM_SOURCES);

    t_state r_state, n_state;
    t_item  r_item;
    logic [EW-1:0] r_entry;
    logic [NUM_ENTRIES-1:0] r_held, n_held;
    logic          r_placed, n_placed;
    logic [SW-1:0] r_k, n_k;
    logic [SW-1:0] r_pk;
    logic          r_pv;

    logic               r_af, n_af, r_bf, n_bf;
    logic signed [31:0] r_ap, n_ap, r_bp, n_bp;
    logic [TW-1:0]      r_at, n_at, r_bt, n_bt;
    logic [CW-1:0]      r_rm, n_rm;

    t_quote  r_quote_mem [NUM_ENTRIES];
    t_quote  r_rd_a, r_rd_b;
    logic    mem_we;
    logic [EW-1:0] rd_addr_a, rd_addr_b;
    logic [EW-1:0] pa_idx, pb_idx;

    t_result r_result;
    logic    r_strobe;

    logic accept;
    logic src_ok;
    logic held_e;
    logic rm_a, rm_b;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign src_ok = ({3'b000, r_item.source_index} < NS7);
    assign held_e = r_held[r_entry];

    assign rd_addr_a = (r_state == S_IDLE) ? entry_of(i_item.side, i_item.source_index)
                                           : EW'(r_k);
    assign rd_addr_b = EW'(NUM_SOURCES) + EW'(r_k);
    assign pa_idx    = EW'(r_pk);
    assign pb_idx    = EW'(NUM_SOURCES) + EW'(r_pk);

    // quote memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_quote_mem[r_entry] <= '{price: r_item.price, size: r_item.size};
        end
        r_rd_a <= r_quote_mem[rd_addr_a];
        r_rd_b <= r_quote_mem[rd_addr_b];
    end

    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_placed = r_placed;
        n_k      = r_k;
        n_af     = r_af;
        n_ap     = r_ap;
        n_at     = r_at;
        n_bf     = r_bf;
        n_bp     = r_bp;
        n_bt     = r_bt;
        n_rm     = r_rm;
        mem_we   = 1'b0;
        rm_a     = 1'b0;
        rm_b     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_placed = 1'b0;
                n_k      = '0;
                n_af     = 1'b0;
                n_ap     = '0;
                n_at     = '0;
                n_bf     = 1'b0;
                n_bp     = '0;
                n_bt     = '0;
                n_rm     = '0;
                if (r_item.req_type == REQ_CLEAR) begin
                    n_held = '0;
                end else if (src_ok) begin
                    // r_rd_a holds the addressed entry, read at accept
                    if (r_item.price > 32'sd0 && (!held_e || r_item.price != r_rd_a.price)) begin
                        n_placed         = 1'b1;
                        n_held[r_entry]  = 1'b1;
                        mem_we           = 1'b1;
                    end else if (held_e && r_item.price <= 32'sd0) begin
                        n_held[r_entry]  = 1'b0;
                    end
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_k = r_k + 1'b1;
                if (r_k == SW'(NUM_SOURCES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one ask and one bid entry per cycle, in the cycle after their read
        if (r_pv) begin
            if (r_held[pa_idx]) begin
                if (r_placed && r_item.side == SIDE_BID && r_rd_a.price < r_item.price) begin
                    rm_a           = 1'b1;
                    n_held[pa_idx] = 1'b0;
                end else if (!r_af || r_rd_a.price < r_ap) begin
                    n_af = 1'b1;
                    n_ap = r_rd_a.price;
                    n_at = TW'(r_rd_a.size);
                end else if (r_rd_a.price == r_ap) begin
                    n_at = r_at + TW'(r_rd_a.size);
                end
            end
            if (r_held[pb_idx]) begin
                if (r_placed && r_item.side == SIDE_ASK && r_rd_b.price > r_item.price) begin
                    rm_b           = 1'b1;
                    n_held[pb_idx] = 1'b0;
                end else if (!r_bf || r_rd_b.price > r_bp) begin
                    n_bf = 1'b1;
                    n_bp = r_rd_b.price;
                    n_bt = TW'(r_rd_b.size);
                end else if (r_rd_b.price == r_bp) begin
                    n_bt = r_bt + TW'(r_rd_b.size);
                end
            end
            n_rm = r_rm + CW'(rm_a) + CW'(rm_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
            r_placed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_pv     <= (r_state == S_SCAN);
            r_strobe <= (r_state == S_DRAIN);
            r_placed <= n_placed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item  <= i_item;
            r_entry <= entry_of(i_item.side, i_item.source_index);
        end
        r_k  <= n_k;
        r_pk <= r_k;
        r_af <= n_af;
        r_ap <= n_ap;
        r_at <= n_at;
        r_bf <= n_bf;
        r_bp <= n_bp;
        r_bt <= n_bt;
        r_rm <= n_rm;
        if (r_state == S_DRAIN) begin
            r_result.ask_present     <= n_af;
            r_result.best_ask_price  <= n_ap;
            r_result.best_ask_total  <= n_at;
            r_result.bid_present     <= n_bf;
            r_result.best_bid_price  <= n_bp;
            r_result.best_bid_total  <= n_bt;
            r_result.crossed_removed <= n_rm;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_clear_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_item.req_type == REQ_CLEAR) |->
            (o_result.crossed_removed == '0 && !o_result.ask_present && !o_result.bid_present))
        else $error("clear left quotes or removal count");

    a_empty_side_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.ask_present) |->
            (o_result.best_ask_price == 32'sd0 && o_result.best_ask_total == '0))
        else $error("empty ask side reports a level");

endmodule
`default_nettype wire

[tb/consolidated_quote_book_top_tb.sv]
// Testbench for the consolidated quote book: directed and random quote traffic checked by a scoreboard.
`timescale 1ns / 1ps
module consolidated_quote_book_top_tb;
    import cqb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 2 * (NUM_SOURCES + 3);
    localparam int RANDOM_ITEMS   = 850;

    // Shadow book plus the queue of expected best levels.
    class book_scoreboard;
        bit                 quote_on[NUM_ENTRIES];
        logic signed [31:0] quote_px[NUM_ENTRIES];
        logic [31:0]        quote_sz[NUM_ENTRIES];
        t_result            expected_levels[$];
        int unsigned        mismatches;
        int unsigned        results_seen;
        int unsigned        items_seen;
        int unsigned        clears_seen;
        int unsigned        withdraws_seen;
        int unsigned        crossed_total;

        function new();
            foreach (quote_on[k]) quote_on[k] = 1'b0;
            mismatches     = 0;
            results_seen   = 0;
            items_seen     = 0;
            clears_seen    = 0;
            withdraws_seen = 0;
            crossed_total  = 0;
        endfunction

        function int entry(input logic sd, input logic [3:0] src);
            return ((sd == SIDE_BID) ? NUM_SOURCES : 0) + int'(src);
        endfunction

        function int unsigned place_quote(input logic sd, input logic [3:0] src,
                                          input logic signed [31:0] px,
                                          input logic [31:0] sz);
            int e;
            int o;
            int unsigned removed;
            removed = 0;
            e = entry(sd, src);
            quote_on[e] = 1'b1;
            quote_px[e] = px;
            quote_sz[e] = sz;
            for (int k = 0; k < NUM_SOURCES; k++) begin
                o = ((sd == SIDE_ASK) ? NUM_SOURCES : 0) + k;
                // strict crossing only; locked quotes stay
                if (quote_on[o] && ((sd == SIDE_ASK) ? (quote_px[o] > px) : (quote_px[o] < px))) begin
                    quote_on[o] = 1'b0;
                    removed++;
                end
            end
            return removed;
        endfunction

        function void best_level(input logic sd, output logic present,
                                 output logic signed [31:0] best, output logic [TW-1:0] total);
            int e;
            present = 1'b0;
            best    = '0;
            total   = '0;
            for (int k = 0; k < NUM_SOURCES; k++) begin
                e = ((sd == SIDE_BID) ? NUM_SOURCES : 0) + k;
                if (!quote_on[e]) continue;
                if (!present) begin
                    present = 1'b1;
                    best    = quote_px[e];
                    total   = TW'(quote_sz[e]);
                end else if (quote_px[e] == best) begin
                    total = total + TW'(quote_sz[e]);
                end else if ((sd == SIDE_ASK) ? (quote_px[e] < best) : (quote_px[e] > best)) begin
                    best  = quote_px[e];
                    total = TW'(quote_sz[e]);
                end
            end
        endfunction

        function void note_quote(input t_item it);
            t_result            want;
            logic signed [31:0] px;
            int                 e;
            int unsigned        removed;
            removed = 0;
            px = it.price;
            items_seen++;
            if (it.req_type == REQ_CLEAR) begin
                foreach (quote_on[k]) quote_on[k] = 1'b0;
                clears_seen++;
            end else if (int'(it.source_index) < NUM_SOURCES) begin
                e = entry(it.side, it.source_index);
                if (px > 0) begin
                    if (!quote_on[e] || px != quote_px[e])
                        removed = place_quote(it.side, it.source_index, px, it.size);
                end else begin
                    quote_on[e] = 1'b0;
                    withdraws_seen++;
                end
            end
            crossed_total += removed;
            best_level(SIDE_ASK, want.ask_present, want.best_ask_price, want.best_ask_total);
            best_level(SIDE_BID, want.bid_present, want.best_bid_price, want.best_bid_total);
            want.crossed_removed = CW'(removed);
            expected_levels.push_back(want);
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, msg);
            mismatches++;
        endtask

        task check_levels(input t_result got);
            t_result want;
            results_seen++;
            if (expected_levels.size() == 0) begin
                report_mismatch($sformatf("result with no transaction pending: %h", got));
                return;
            end
            want = expected_levels.pop_front();
            if (got.ask_present !== want.ask_present)
                report_mismatch($sformatf("ask_present got %b want %b",
                                          got.ask_present, want.ask_present));
            if (got.best_ask_price !== want.best_ask_price)
                report_mismatch($sformatf("best_ask_price got %h want %h",
                                          got.best_ask_price, want.best_ask_price));
            if (got.best_ask_total !== want.best_ask_total)
                report_mismatch($sformatf("best_ask_total got %h want %h",
                                          got.best_ask_total, want.best_ask_total));
            if (got.bid_present !== want.bid_present)
                report_mismatch($sformatf("bid_present got %b want %b",
                                          got.bid_present, want.bid_present));
            if (got.best_bid_price !== want.best_bid_price)
                report_mismatch($sformatf("best_bid_price got %h want %h",
                                          got.best_bid_price, want.best_bid_price));
            if (got.best_bid_total !== want.best_bid_total)
                report_mismatch($sformatf("best_bid_total got %h want %h",
                                          got.best_bid_total, want.best_bid_total));
            if (got.crossed_removed !== want.crossed_removed)
                report_mismatch($sformatf("crossed_removed got %0d want %0d",
                                          got.crossed_removed, want.crossed_removed));
        endtask

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;

    book_scoreboard board = new();
    bit             idle_on;
    int             quiet_cycles;

    consolidated_quote_book_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_levels(o_result);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        @(posedge i_clk);
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, board.pending());
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_item make_item(input logic req, input logic sd, input logic [3:0] src,
                                        input logic [31:0] px, input logic [31:0] sz);
        t_item it;
        it.req_type     = req;
        it.side         = sd;
        it.source_index = src;
        it.price        = px;
        it.size         = sz;
        return it;
    endfunction

    // Hold start until the transaction is taken; random gaps land on any phase of the sweep.
    task automatic send_item(input t_item it);
        int gap;
        if (idle_on && $urandom_range(0, 99) < 18) begin
            start  <= 1'b0;
            i_item <= make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                4'($urandom_range(0, 15)), $urandom, $urandom);
            gap = $urandom_range(1, 25);
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!(start && !busy));
        board.note_quote(it);
    endtask

    task automatic make_random(output t_item it);
        int         pick;
        int         e;
        logic       sd;
        logic [3:0] src;
        pick = $urandom_range(0, 99);
        sd   = 1'($urandom_range(0, 1));
        src  = 4'($urandom_range(0, 15));
        e    = board.entry(sd, src);
        it   = make_item(REQ_UPDATE, sd, src, '0,
                         $urandom_range(0, 1) ? $urandom : $urandom_range(1, 500));
        if (pick < 3) begin
            it = make_item(REQ_CLEAR, sd, src, $urandom, $urandom);
        end else if (pick < 15) begin
            case ($urandom_range(0, 3))
                0:       it.price = '0;
                1:       it.price = 32'h8000_0000;
                2:       it.price = 32'd0 - 32'($urandom_range(1, 1000));
                default: it.price = {1'b1, 31'($urandom)};
            endcase
        end else if (pick < 27 && board.quote_on[e]) begin
            // re-quote at the held price: size must stay stale
            it.price = board.quote_px[e];
        end else if (pick < 32) begin
            it.price = $urandom;
        end else begin
            // narrow band so crossing and locked levels happen often
            it.price = (sd == SIDE_ASK) ? 32'(1000 + $urandom_range(0, 12))
                                        : 32'(994 + $urandom_range(0, 12));
        end
    endtask

    initial begin
        t_item it;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        idle_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: placement, stale size, locked, crossing, withdrawals, clear
        send_item(make_item(REQ_UPDATE, SIDE_ASK, 4'd0, 32'd100, 32'd10));
        send_item(make_item(REQ_UPDATE, SIDE_ASK, 4'd1, 32'd100, 32'hFFFF_FFFF));
        send_item(make_item(REQ_UPDATE, SIDE_ASK, 4'd1, 32'd100, 32'd7));
        send_item(make_item(REQ_UPDATE, SIDE_BID, 4'd2, 32'd100, 32'd3));
        send_item(make_item(REQ_UPDATE, SIDE_BID, 4'd3, 32'd101, 32'd1));
        send_item(make_item(REQ_UPDATE, SIDE_BID, 4'd3, 32'd0, 32'd0));
        send_item(make_item(REQ_UPDATE, SIDE_ASK, 4'd5, 32'hFFFF_FFFF, 32'd9));
        send_item(make_item(REQ_UPDATE, SIDE_BID, 4'd2, 32'h8000_0000, 32'hFFFF_FFFF));
        send_item(make_item(REQ_CLEAR, SIDE_BID, 4'd15, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        // full bid side at the top price and size, then one ask that sweeps it all
        for (int k = 0; k < NUM_SOURCES; k++)
            send_item(make_item(REQ_UPDATE, SIDE_BID, 4'(k), 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(REQ_UPDATE, SIDE_ASK, 4'd15, 32'd1, 32'd0));
        send_item(make_item(REQ_CLEAR, SIDE_ASK, 4'd0, 32'd0, 32'd0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 300 && n < 450);
            make_random(it);
            send_item(it);
        end
        start <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d quote transactions: %0d clears, %0d withdrawals, %0d crossed quotes removed",
                 board.items_seen, board.clears_seen, board.withdraws_seen, board.crossed_total);
        $display("Checked %0d best-level results, %0d mismatches",
                 board.results_seen, board.mismatches);
        if (board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
